FILE: design/assert_macros.svh
// Assertion helpers included by the core design file.
// Each macro builds one labeled concurrent assertion on a clock with an
// active-low reset that disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg: two-link inverse kinematics shared types and constants
// Sequencer states, register indexes, fixed-point constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlik_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_RATE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RATE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_DIR     = 3'd4;

	localparam logic [15:0] LEN_RESET  = 16'd2560;
	localparam logic [15:0] RATE_RESET = 16'd328;
	localparam logic signed [26:0] TARGET_X_RESET = 27'sd1310720;

	localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
	localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;
	localparam logic signed [25:0] DEG16_90 = 26'sd5898240;
	localparam logic signed [34:0] NORM_LIMIT = 35'sd536870912;
	localparam int ANGLE_LIMIT = 46080;

	typedef enum logic [4:0] {
		ST_IDLE, ST_JOGX, ST_JOGY, ST_TY, ST_CLAMP, ST_SQX, ST_SQY, ST_L1S, ST_L2S,
		ST_L12, ST_NUM1, ST_DIVCHK, ST_DIVW, ST_CSQ, ST_RADIC, ST_ROOTW, ST_ACOS,
		ST_ACOSW, ST_DIST, ST_DISTW, ST_LDEN, ST_NUM2, ST_ATAN, ST_ATANW, ST_FIN
	} seq_state_t;

	typedef enum logic [1:0] {CK_IDLE, CK_NORM, CK_ROT, CK_ITER} ck_phase_t;

	typedef struct packed {
		logic start;
		logic op_sqrt;
	} ds_cmd_t;

	// atan(2^-i) in units of 2^-16 degree, rounded to nearest.
	function automatic logic [21:0] atan_deg16(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: design/tlik_ifs.sv
// ----------------------------------------------------------------------------
// tlik_ifs: channel interfaces
// Joystick input words, result words and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlik_joy_if;
	logic valid;
	logic ready;
	logic signed [7:0] x_axis_percent;
	logic signed [7:0] y_axis_percent;
	modport source(output valid, x_axis_percent, y_axis_percent, input ready);
	modport sink(input valid, x_axis_percent, y_axis_percent, output ready);
endinterface

interface tlik_res_if;
	logic valid;
	logic ready;
	logic signed [16:0] shoulder_angle;
	logic [15:0] elbow_angle;
	logic signed [17:0] target_x_out;
	logic [16:0] target_y_out;
	logic at_origin;
	modport source(output valid, shoulder_angle, elbow_angle, target_x_out, target_y_out,
		at_origin, input ready);
	modport sink(input valid, shoulder_angle, elbow_angle, target_x_out, target_y_out,
		at_origin, output ready);
endinterface

interface tlik_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/tlik_divsqrt.sv
// ----------------------------------------------------------------------------
// tlik_divsqrt: shared restoring divider and integer square root
// One compare-and-subtract per cycle: 30 quotient bits for a division, or
// 31 root bits for a square root of a value below 2^61.
// ----------------------------------------------------------------------------
`default_nettype none

module tlik_divsqrt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tlik_pkg::ds_cmd_t  cmd,
	input  wire logic [60:0]   a,
	input  wire logic [51:0]   b,
	output logic               done,
	output logic [30:0]        res
);

	logic [60:0] acc_q, aux_q, bit_q;
	logic [51:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q, op_q, done_q;
	logic [61:0] lhs, rhs, diff;
	logic        ge;
	logic [60:0] aux_sqrt;

	// Divide: shift the remainder left, then try the divisor.
	// Root: try r + bit against the remaining radicand.
	always_comb begin
		lhs = op_q ? {1'b0, acc_q} : {acc_q, 1'b0};
		rhs = op_q ? ({1'b0, aux_q} + {1'b0, bit_q}) : {10'b0, den_q};
		ge = lhs >= rhs;
		diff = lhs - rhs;
		aux_sqrt = ge ? ((aux_q >> 1) + bit_q) : (aux_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.op_sqrt ? 5'd30 : 5'd29;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= a;
			aux_q <= '0;
			bit_q <= 61'(1) << 60;
			den_q <= b;
			op_q <= cmd.op_sqrt;
		end else if (busy_q) begin
			acc_q <= ge ? diff[60:0] : lhs[60:0];
			aux_q <= op_q ? aux_sqrt : {aux_q[59:0], ge};
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign res = aux_q[30:0];

endmodule

`default_nettype wire

FILE: design/tlik_cordic.sv
// ----------------------------------------------------------------------------
// tlik_cordic: iterative vectoring CORDIC for atan2
// Normalizes the operands one doubling per cycle, pre-rotates into the right
// half plane, then runs one micro-rotation per cycle. Angle in 2^-16 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module tlik_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] y_in,
	input  wire logic signed [31:0] x_in,
	output logic                    done,
	output logic signed [25:0]      angle
);

	localparam int IW = $clog2(STEPS);
	localparam logic [IW-1:0] I_LAST = IW'(STEPS - 1);

	tlik_pkg::ck_phase_t phase_q, phase_d;
	logic signed [34:0] x_q, y_q, dx, dy;
	logic signed [25:0] z_q, tbl;
	logic [IW-1:0] i_q;
	logic done_q, below_lim, in_zero;

	always_comb begin
		below_lim = (x_q > -tlik_pkg::NORM_LIMIT) && (x_q < tlik_pkg::NORM_LIMIT) &&
			(y_q > -tlik_pkg::NORM_LIMIT) && (y_q < tlik_pkg::NORM_LIMIT);
		in_zero = (x_in == 32'sd0) && (y_in == 32'sd0);
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		tbl = $signed({4'b0, tlik_pkg::atan_deg16(5'(i_q))});
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			tlik_pkg::CK_IDLE: begin
				if (start && !in_zero) phase_d = tlik_pkg::CK_NORM;
			end
			tlik_pkg::CK_NORM: begin
				if (!below_lim) phase_d = tlik_pkg::CK_ROT;
			end
			tlik_pkg::CK_ROT: phase_d = tlik_pkg::CK_ITER;
			tlik_pkg::CK_ITER: begin
				if (i_q == I_LAST) phase_d = tlik_pkg::CK_IDLE;
			end
			default: phase_d = tlik_pkg::CK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlik_pkg::CK_IDLE;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			phase_q <= phase_d;
			done_q <= (phase_q == tlik_pkg::CK_IDLE && start && in_zero) ||
				(phase_q == tlik_pkg::CK_ITER && i_q == I_LAST);
			if (phase_q == tlik_pkg::CK_ITER) i_q <= i_q + IW'(1);
			else i_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			tlik_pkg::CK_IDLE: begin
				if (start) begin
					x_q <= 35'(x_in);
					y_q <= 35'(y_in);
					z_q <= '0;
				end
			end
			tlik_pkg::CK_NORM: begin
				if (below_lim) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			tlik_pkg::CK_ROT: begin
				// Quarter turn into the right half plane.
				if (x_q < 35'sd0) begin
					if (y_q >= 35'sd0) begin
						x_q <= y_q;
						y_q <= -x_q;
						z_q <= tlik_pkg::DEG16_90;
					end else begin
						x_q <= -y_q;
						y_q <= x_q;
						z_q <= -tlik_pkg::DEG16_90;
					end
				end
			end
			tlik_pkg::CK_ITER: begin
				if (y_q >= 35'sd0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + tbl;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - tbl;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign angle = z_q;

endmodule

`default_nettype wire

FILE: design/two_link_arm_inverse_kinematics_core.sv
// Each word runs through the shared divider/root unit (one division or root per pass,
// up to five passes) and the CORDIC (normalize, pre-rotate, then CORDIC_STEPS
// micro-rotations per pass, up to three passes). One word is in work at a time;
// the next can be taken in the cycle after the result is registered, and an
// output stall holds the core in FIN until the result slot is free.
// Reset: asynchronous, active low; registers to defaults, target point to (20.0, 0).
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_core: joystick driven two-link arm solver
// Jogs a stored target point, clamps it to the reach and solves shoulder and
// elbow angles with one shared multiplier, a divider/root unit and a CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module two_link_arm_inverse_kinematics_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlik_joy_if.sink   joy,
	tlik_res_if.source result,
	tlik_cfg_if.sink   cfg
);

	tlik_pkg::seq_state_t state_q, state_d;

	logic [15:0] l1_len_q, l2_len_q, xr_q, yr_q;
	logic        xdir_q;

	logic signed [7:0]  ax_q, ay_q;
	logic signed [26:0] tx_q, ty_q;
	logic [63:0]        p_q;
	logic [51:0]        d2_q, den_q;
	logic [47:0]        l1s_q, l2s_q;
	logic signed [53:0] num_q;
	logic signed [31:0] c_q;
	logic [30:0]        root_q;
	logic [25:0]        dist_q;
	logic signed [25:0] elbow16_q, acos2_q;
	logic signed [26:0] shoulder16_q;
	logic               origin_q, ph_q;
	logic               out_valid_q;

	logic [23:0] l1, l2;
	logic [24:0] reach;
	logic signed [26:0] reach_s, tx_neg;
	logic [25:0] tx_abs;
	logic [7:0]  ax_abs, ay_abs;
	logic signed [7:0] ax_neg, ay_neg;
	logic [31:0] mul_a, mul_b;
	logic [22:0] jog;
	logic signed [53:0] num_neg;
	logic [52:0] mag;
	logic        sat, out_free;
	logic signed [31:0] c_neg;
	logic [30:0] c_abs;

	tlik_pkg::ds_cmd_t ds_cmd;
	logic [60:0] ds_a;
	logic        ds_done;
	logic [30:0] ds_res;

	logic               ck_start, ck_done;
	logic signed [31:0] ck_y, ck_x;
	logic signed [25:0] ck_angle;

	logic signed [26:0] e_rnd;
	logic signed [18:0] e_deg;
	logic signed [27:0] s_rnd;
	logic signed [19:0] s_deg;
	logic [15:0]        elbow_out;
	logic signed [16:0] shoulder_out;

	always_comb begin
		l1 = {l1_len_q, 8'b0};
		l2 = {l2_len_q, 8'b0};
		reach = {1'b0, l1} + {1'b0, l2};
		reach_s = $signed({2'b00, reach});
		tx_neg = -tx_q;
		tx_abs = tx_q[26] ? tx_neg[25:0] : tx_q[25:0];
		ax_neg = -ax_q;
		ay_neg = -ay_q;
		ax_abs = ax_q[7] ? ax_neg : ax_q;
		ay_abs = ay_q[7] ? ay_neg : ay_q;
		jog = p_q[22:0];
		num_neg = -num_q;
		mag = num_q[53] ? num_neg[52:0] : num_q[52:0];
		sat = mag >= {1'b0, den_q};
		c_neg = -c_q;
		c_abs = c_q[31] ? c_neg[30:0] : c_q[30:0];
		out_free = !out_valid_q || result.ready;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlik_pkg::ST_IDLE:   if (joy.valid) state_d = tlik_pkg::ST_JOGX;
			tlik_pkg::ST_JOGX:   state_d = tlik_pkg::ST_JOGY;
			tlik_pkg::ST_JOGY:   state_d = tlik_pkg::ST_TY;
			tlik_pkg::ST_TY:     state_d = tlik_pkg::ST_CLAMP;
			tlik_pkg::ST_CLAMP:  state_d = tlik_pkg::ST_SQX;
			tlik_pkg::ST_SQX:    state_d = tlik_pkg::ST_SQY;
			tlik_pkg::ST_SQY:    state_d = tlik_pkg::ST_L1S;
			tlik_pkg::ST_L1S:    state_d = tlik_pkg::ST_L2S;
			tlik_pkg::ST_L2S:    state_d = tlik_pkg::ST_L12;
			tlik_pkg::ST_L12:    state_d = tlik_pkg::ST_NUM1;
			tlik_pkg::ST_NUM1:   state_d = tlik_pkg::ST_DIVCHK;
			tlik_pkg::ST_DIVCHK: state_d = sat ? tlik_pkg::ST_CSQ : tlik_pkg::ST_DIVW;
			tlik_pkg::ST_DIVW:   if (ds_done) state_d = tlik_pkg::ST_CSQ;
			tlik_pkg::ST_CSQ:    state_d = tlik_pkg::ST_RADIC;
			tlik_pkg::ST_RADIC:  state_d = tlik_pkg::ST_ROOTW;
			tlik_pkg::ST_ROOTW:  if (ds_done) state_d = tlik_pkg::ST_ACOS;
			tlik_pkg::ST_ACOS:   state_d = tlik_pkg::ST_ACOSW;
			tlik_pkg::ST_ACOSW: begin
				if (ck_done) begin
					if (ph_q) state_d = tlik_pkg::ST_ATAN;
					else if (d2_q == 52'd0) state_d = tlik_pkg::ST_FIN;
					else state_d = tlik_pkg::ST_DIST;
				end
			end
			tlik_pkg::ST_DIST:   state_d = tlik_pkg::ST_DISTW;
			tlik_pkg::ST_DISTW:  if (ds_done) state_d = tlik_pkg::ST_LDEN;
			tlik_pkg::ST_LDEN:   state_d = tlik_pkg::ST_NUM2;
			tlik_pkg::ST_NUM2:   state_d = tlik_pkg::ST_DIVCHK;
			tlik_pkg::ST_ATAN:   state_d = tlik_pkg::ST_ATANW;
			tlik_pkg::ST_ATANW:  if (ck_done) state_d = tlik_pkg::ST_FIN;
			tlik_pkg::ST_FIN:    if (out_free) state_d = tlik_pkg::ST_IDLE;
			default:             state_d = tlik_pkg::ST_IDLE;
		endcase
	end

	// Unit commands and multiplier operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		ds_cmd = '0;
		ds_a = '0;
		ck_start = 1'b0;
		ck_y = $signed({1'b0, root_q});
		ck_x = c_q;
		case (state_q)
			tlik_pkg::ST_JOGX: begin
				mul_a = {24'b0, ax_abs};
				mul_b = {16'b0, xr_q};
			end
			tlik_pkg::ST_JOGY: begin
				mul_a = {24'b0, ay_abs};
				mul_b = {16'b0, yr_q};
			end
			tlik_pkg::ST_SQX: begin
				mul_a = {6'b0, tx_abs};
				mul_b = {6'b0, tx_abs};
			end
			tlik_pkg::ST_SQY: begin
				mul_a = {6'b0, ty_q[25:0]};
				mul_b = {6'b0, ty_q[25:0]};
			end
			tlik_pkg::ST_L1S: begin
				mul_a = {8'b0, l1};
				mul_b = {8'b0, l1};
			end
			tlik_pkg::ST_L2S: begin
				mul_a = {8'b0, l2};
				mul_b = {8'b0, l2};
			end
			tlik_pkg::ST_L12: begin
				mul_a = {8'b0, l1};
				mul_b = {8'b0, l2};
			end
			tlik_pkg::ST_CSQ: begin
				mul_a = {1'b0, c_abs};
				mul_b = {1'b0, c_abs};
			end
			tlik_pkg::ST_LDEN: begin
				mul_a = {8'b0, l1};
				mul_b = {6'b0, dist_q};
			end
			tlik_pkg::ST_DIVCHK: begin
				ds_cmd.start = !sat;
				ds_a = {8'b0, mag};
			end
			tlik_pkg::ST_RADIC: begin
				ds_cmd.start = 1'b1;
				ds_cmd.op_sqrt = 1'b1;
				ds_a = tlik_pkg::ONE_Q60 - p_q[60:0];
			end
			tlik_pkg::ST_DIST: begin
				ds_cmd.start = 1'b1;
				ds_cmd.op_sqrt = 1'b1;
				ds_a = {9'b0, d2_q};
			end
			tlik_pkg::ST_ACOS: ck_start = 1'b1;
			tlik_pkg::ST_ATAN: begin
				ck_start = 1'b1;
				ck_y = 32'(ty_q);
				ck_x = 32'(tx_q);
			end
			default: begin
			end
		endcase
	end

	tlik_divsqrt u_divsqrt (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(ds_cmd),
		.a(ds_a),
		.b(den_q),
		.done(ds_done),
		.res(ds_res)
	);

	tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(ck_start),
		.y_in(ck_y),
		.x_in(ck_x),
		.done(ck_done),
		.angle(ck_angle)
	);

	// Round half up to 1/256 degree, then clamp.
	always_comb begin
		e_rnd = 27'(elbow16_q) + 27'sd128;
		e_deg = 19'(e_rnd >>> 8);
		if (e_deg < 19'sd0) elbow_out = 16'd0;
		else if (e_deg > 19'(tlik_pkg::ANGLE_LIMIT)) elbow_out = 16'(tlik_pkg::ANGLE_LIMIT);
		else elbow_out = e_deg[15:0];
		s_rnd = 28'(shoulder16_q) + 28'sd128;
		s_deg = 20'(s_rnd >>> 8);
		if (s_deg < -20'(tlik_pkg::ANGLE_LIMIT)) shoulder_out = -17'(tlik_pkg::ANGLE_LIMIT);
		else if (s_deg > 20'(tlik_pkg::ANGLE_LIMIT))
			shoulder_out = 17'(tlik_pkg::ANGLE_LIMIT);
		else shoulder_out = s_deg[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlik_pkg::ST_IDLE;
			l1_len_q <= tlik_pkg::LEN_RESET;
			l2_len_q <= tlik_pkg::LEN_RESET;
			xr_q <= tlik_pkg::RATE_RESET;
			yr_q <= tlik_pkg::RATE_RESET;
			xdir_q <= 1'b1;
			tx_q <= tlik_pkg::TARGET_X_RESET;
			ty_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					tlik_pkg::REG_UPPER_LEN: l1_len_q <= cfg.data;
					tlik_pkg::REG_LOWER_LEN: l2_len_q <= cfg.data;
					tlik_pkg::REG_X_RATE:    xr_q <= cfg.data;
					tlik_pkg::REG_Y_RATE:    yr_q <= cfg.data;
					tlik_pkg::REG_X_DIR:     xdir_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
			case (state_q)
				tlik_pkg::ST_JOGY: begin
					// The X step is subtracted when exactly one of axis sign and
					// reversed direction holds.
					if (ax_q[7] ^ !xdir_q) tx_q <= tx_q - 27'(jog);
					else tx_q <= tx_q + 27'(jog);
				end
				tlik_pkg::ST_TY: begin
					if (ay_q[7]) ty_q <= ty_q - 27'(jog);
					else ty_q <= ty_q + 27'(jog);
					if (tx_q < -reach_s) tx_q <= -reach_s;
					else if (tx_q > reach_s) tx_q <= reach_s;
				end
				tlik_pkg::ST_CLAMP: begin
					if (ty_q < 27'sd0) ty_q <= '0;
					else if (ty_q > reach_s) ty_q <= reach_s;
				end
				default: begin
				end
			endcase
			if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			if (state_q == tlik_pkg::ST_FIN && out_free) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (state_q == tlik_pkg::ST_IDLE && joy.valid) begin
			ax_q <= joy.x_axis_percent;
			ay_q <= joy.y_axis_percent;
		end
		case (state_q)
			tlik_pkg::ST_SQY: d2_q <= p_q[51:0];
			tlik_pkg::ST_L1S: d2_q <= d2_q + p_q[51:0];
			tlik_pkg::ST_L2S: l1s_q <= p_q[47:0];
			tlik_pkg::ST_L12: l2s_q <= p_q[47:0];
			tlik_pkg::ST_NUM1: begin
				den_q <= {p_q[50:0], 1'b0};
				num_q <= $signed({2'b00, d2_q}) - $signed({6'b0, l1s_q}) -
					$signed({6'b0, l2s_q});
				ph_q <= 1'b0;
			end
			tlik_pkg::ST_NUM2: begin
				den_q <= {p_q[50:0], 1'b0};
				num_q <= $signed({2'b00, d2_q}) + $signed({6'b0, l1s_q}) -
					$signed({6'b0, l2s_q});
				ph_q <= 1'b1;
			end
			tlik_pkg::ST_DIVCHK: begin
				if (sat) c_q <= num_q[53] ? -tlik_pkg::Q30_ONE : tlik_pkg::Q30_ONE;
			end
			tlik_pkg::ST_DIVW: begin
				if (ds_done) begin
					if (num_q[53]) c_q <= -$signed({2'b00, ds_res[29:0]});
					else c_q <= $signed({2'b00, ds_res[29:0]});
				end
			end
			tlik_pkg::ST_ROOTW: if (ds_done) root_q <= ds_res;
			tlik_pkg::ST_DISTW: if (ds_done) dist_q <= ds_res[25:0];
			tlik_pkg::ST_ACOSW: begin
				if (ck_done) begin
					if (ph_q) acos2_q <= ck_angle;
					else begin
						elbow16_q <= ck_angle;
						origin_q <= d2_q == 52'd0;
						shoulder16_q <= '0;
					end
				end
			end
			tlik_pkg::ST_ATANW: begin
				if (ck_done) shoulder16_q <= 27'(ck_angle) - 27'(acos2_q);
			end
			tlik_pkg::ST_FIN: begin
				if (out_free) begin
					result.shoulder_angle <= shoulder_out;
					result.elbow_angle <= elbow_out;
					result.target_x_out <= tx_q[25:8];
					result.target_y_out <= ty_q[24:8];
					result.at_origin <= origin_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign joy.ready = state_q == tlik_pkg::ST_IDLE;
	assign cfg.ready = 1'b1;
	assign result.valid = out_valid_q;

	`ASSERT_NEXT(a_one_word_in_work, clk, arst_n, joy.valid && joy.ready, !joy.ready,
		"second word accepted while busy")
	`ASSERT_IMPL(a_origin_shoulder, clk, arst_n, result.valid && result.at_origin,
		result.shoulder_angle == 17'sd0, "shoulder not zero at origin")
	`ASSERT_IMPL(a_elbow_range, clk, arst_n, result.valid,
		result.elbow_angle <= 16'd46080, "elbow angle out of range")
	`ASSERT_IMPL(a_ds_done_expected, clk, arst_n, ds_done,
		state_q == tlik_pkg::ST_DIVW || state_q == tlik_pkg::ST_ROOTW ||
		state_q == tlik_pkg::ST_DISTW, "divider finished while not awaited")

endmodule

`default_nettype wire

FILE: sim/two_link_arm_inverse_kinematics_core_test.sv
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics core testbench
// Drives joystick words and register writes into the core and checks every
// result word against a fixed-point solver model kept inside the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
	logic signed [16:0] shoulder;
	logic [15:0] elbow;
	logic signed [17:0] tx;
	logic [16:0] ty;
	logic origin;
} ik_word_t;

class ik_scoreboard;
	ik_word_t pending[$];
	int errors;
	longint upper_len, lower_len, x_rate, y_rate, x_pos;
	longint tgt_x, tgt_y;
	longint atan_tab[24];

	function new();
		atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		upper_len = longint'(tlik_pkg::LEN_RESET);
		lower_len = longint'(tlik_pkg::LEN_RESET);
		x_rate = longint'(tlik_pkg::RATE_RESET);
		y_rate = longint'(tlik_pkg::RATE_RESET);
		x_pos = 1;
		tgt_x = 1310720;
		tgt_y = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			tlik_pkg::REG_UPPER_LEN: upper_len = longint'(v);
			tlik_pkg::REG_LOWER_LEN: lower_len = longint'(v);
			tlik_pkg::REG_X_RATE: x_rate = longint'(v);
			tlik_pkg::REG_Y_RATE: y_rate = longint'(v);
			tlik_pkg::REG_X_DIR: x_pos = longint'(v[0]);
			default: ;
		endcase
	endfunction

	function longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function longint isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function longint cos_q30(longint num, longint unsigned den);
		longint unsigned mag, rem, q;
		mag = num < 0 ? -num : num;
		q = 0;
		if (mag >= den) return num < 0 ? -(64'sd1 << 30) : (64'sd1 << 30);
		rem = mag;
		for (int k = 0; k < 30; k++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function longint arctan2(longint y, longint x);
		longint z, t, ddx, ddy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		while ((x < 0 ? -x : x) < (64'sd1 << 29) && (y < 0 ? -y : y) < (64'sd1 << 29)) begin
			x *= 2;
			y *= 2;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 64'sd90 << 16;
			end else begin
				x = -y; y = t; z = -(64'sd90 << 16);
			end
		end
		for (int i = 0; i < 16; i++) begin
			ddx = fshift(y, i);
			ddy = fshift(x, i);
			if (y >= 0) begin
				x += ddx; y -= ddy; z += atan_tab[i];
			end else begin
				x -= ddx; y += ddy; z -= atan_tab[i];
			end
		end
		return z;
	endfunction

	function longint arccos(longint c);
		longint unsigned s2;
		s2 = (64'd1 << 60) - longint'(c * c);
		return arctan2(isqrt(s2), c);
	endfunction

	function longint to_deg256(longint a, longint lo, longint hi);
		longint r;
		r = fshift(a + 128, 8);
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	function void note_joystick(logic signed [7:0] xp, logic signed [7:0] yp);
		longint l1, l2, reach, l1s, l2s, d2, e16, s16;
		ik_word_t w;
		l1 = upper_len << 8;
		l2 = lower_len << 8;
		reach = l1 + l2;
		if (x_pos != 0) tgt_x += longint'(xp) * x_rate;
		else tgt_x -= longint'(xp) * x_rate;
		tgt_y += longint'(yp) * y_rate;
		if (tgt_x < -reach) tgt_x = -reach;
		if (tgt_x > reach) tgt_x = reach;
		if (tgt_y < 0) tgt_y = 0;
		if (tgt_y > reach) tgt_y = reach;
		l1s = l1 * l1;
		l2s = l2 * l2;
		d2 = tgt_x * tgt_x + tgt_y * tgt_y;
		e16 = arccos(cos_q30(d2 - l1s - l2s, 2 * l1 * l2));
		s16 = 0;
		w.origin = (d2 == 0);
		if (!w.origin)
			s16 = arctan2(tgt_y, tgt_x) - arccos(cos_q30(d2 + l1s - l2s, 2 * l1 * isqrt(d2)));
		w.shoulder = 17'(to_deg256(s16, -tlik_pkg::ANGLE_LIMIT, tlik_pkg::ANGLE_LIMIT));
		w.elbow = 16'(to_deg256(e16, 0, tlik_pkg::ANGLE_LIMIT));
		w.tx = 18'(fshift(tgt_x, 8));
		w.ty = 17'(fshift(tgt_y, 8));
		pending.push_back(w);
	endfunction

	function void check_result(ik_word_t got);
		ik_word_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result word, shoulder %0d", $time, got.shoulder);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.shoulder !== want.shoulder) begin
			$display("%0t: shoulder expected %0d actual %0d", $time, want.shoulder, got.shoulder);
			errors++;
		end
		if (got.elbow !== want.elbow) begin
			$display("%0t: elbow expected %0d actual %0d", $time, want.elbow, got.elbow);
			errors++;
		end
		if (got.tx !== want.tx) begin
			$display("%0t: target x expected %0d actual %0d", $time, want.tx, got.tx);
			errors++;
		end
		if (got.ty !== want.ty) begin
			$display("%0t: target y expected %0d actual %0d", $time, want.ty, got.ty);
			errors++;
		end
		if (got.origin !== want.origin) begin
			$display("%0t: at_origin expected %0b actual %0b", $time, want.origin, got.origin);
			errors++;
		end
	endfunction
endclass

module two_link_arm_inverse_kinematics_core_test;
	logic clk;
	logic arst_n;
	int hold_off;
	ik_scoreboard board;

	tlik_joy_if joy();
	tlik_res_if result();
	tlik_cfg_if cfg();

	two_link_arm_inverse_kinematics_core uut (
		.clk(clk), .arst_n(arst_n), .joy(joy.sink), .result(result.source), .cfg(cfg.sink)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic send_joy(logic signed [7:0] xp, logic signed [7:0] yp, bit idle);
		int g;
		g = idle ? gap_len() : 0;
		repeat (g) @(posedge clk);
		joy.valid <= 1;
		joy.x_axis_percent <= xp;
		joy.y_axis_percent <= yp;
		@(posedge clk);
		while (!joy.ready) @(posedge clk);
		board.note_joystick(xp, yp);
		joy.valid <= 0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.set_reg(idx, v);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// Wait until every expected word has come back, then let the core settle.
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_random(int n);
		logic signed [7:0] xp, yp;
		for (int i = 0; i < n; i++) begin
			xp = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($signed($urandom_range(0, 200)) - 100);
			yp = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($signed($urandom_range(0, 200)) - 100);
			send_joy(xp, yp, 1);
		end
	endtask

	// Result side: random stalls plus an optional long hold-off.
	initial begin
		ik_word_t w;
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				result.ready <= 0;
			end else begin
				result.ready <= ($urandom_range(0, 3) != 0);
			end
			if (result.valid && result.ready) begin
				w.shoulder = result.shoulder_angle;
				w.elbow = result.elbow_angle;
				w.tx = result.target_x_out;
				w.ty = result.target_y_out;
				w.origin = result.at_origin;
				board.check_result(w);
			end
		end
	end

	initial begin
		board = new();
		hold_off = 0;
		arst_n = 0;
		joy.valid = 0;
		joy.x_axis_percent = 0;
		joy.y_axis_percent = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes and the origin case.
		send_joy(100, 100, 0);
		send_joy(-100, -100, 0);
		send_joy(127, 127, 0);
		send_joy(-128, -128, 0);
		send_joy(0, 0, 0);
		drain();
		// Jog to the origin: pin the target at the left reach limit with Y at zero,
		// then step right by exactly the reach.
		write_reg(tlik_pkg::REG_X_RATE, 16'd65535);
		write_reg(tlik_pkg::REG_Y_RATE, 16'd65535);
		write_reg(tlik_pkg::REG_X_DIR, 16'd0);
		send_joy(127, -128, 0);
		send_joy(127, -128, 0);
		drain();
		write_reg(tlik_pkg::REG_X_RATE, 16'd16384);
		send_joy(-80, 0, 0);
		send_joy(-5, 3, 0);
		drain();
		write_reg(tlik_pkg::REG_X_RATE, 16'd0);
		write_reg(tlik_pkg::REG_Y_RATE, 16'd0);
		send_joy(50, 50, 0);
		drain();
		write_reg(tlik_pkg::REG_UPPER_LEN, 16'd1);
		write_reg(tlik_pkg::REG_LOWER_LEN, 16'd65535);
		write_reg(tlik_pkg::REG_X_RATE, 16'd40000);
		write_reg(tlik_pkg::REG_Y_RATE, 16'd300);
		write_reg(tlik_pkg::REG_X_DIR, 16'd1);
		send_joy(-100, 100, 0);
		send_joy(100, 1, 0);
		drain();
		write_reg(tlik_pkg::REG_UPPER_LEN, 16'd65535);
		write_reg(tlik_pkg::REG_LOWER_LEN, 16'd1);
		send_joy(-1, -1, 0);
		send_joy(100, 100, 0);
		drain();

		// Long stall on the result side while words keep coming.
		hold_off = 600;
		send_random(6);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(tlik_pkg::REG_UPPER_LEN,
				16'($urandom_range(1, 65535) >> $urandom_range(0, 8)) | 16'd1);
			write_reg(tlik_pkg::REG_LOWER_LEN,
				16'($urandom_range(1, 65535) >> $urandom_range(0, 8)) | 16'd1);
			write_reg(tlik_pkg::REG_X_RATE, 16'($urandom));
			write_reg(tlik_pkg::REG_Y_RATE,
				16'($urandom_range(0, 65535) >> $urandom_range(0, 10)));
			write_reg(tlik_pkg::REG_X_DIR, 16'($urandom_range(0, 1)));
			send_random(45);
			drain();
		end
		write_reg(tlik_pkg::REG_UPPER_LEN, tlik_pkg::LEN_RESET);
		write_reg(tlik_pkg::REG_LOWER_LEN, tlik_pkg::LEN_RESET);
		write_reg(tlik_pkg::REG_X_RATE, tlik_pkg::RATE_RESET);
		write_reg(tlik_pkg::REG_Y_RATE, tlik_pkg::RATE_RESET);
		send_random(20);
		drain();
		repeat (400) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

FILE: two_link_arm_inverse_kinematics_core.f
+incdir+design
design/tlik_pkg.sv
design/tlik_ifs.sv
design/tlik_divsqrt.sv
design/tlik_cordic.sv
design/two_link_arm_inverse_kinematics_core.sv
sim/two_link_arm_inverse_kinematics_core_test.sv
